### rtl/core/sgrf_pkg.sv
// Shared types and constants for the sensor glitch rejection filter.
// No dependencies; every other file in rtl/core but sgrf_skid refers to it by scoped names.
package sgrf_pkg;

    // Configuration register widths
    localparam int GLITCH_LIMIT_W = 17;
    localparam int TEMP_CFG_W     = 18;
    localparam int HUM_CFG_W      = 17;
    localparam int CFG_DATA_W     = 18;
    localparam int CFG_INDEX_W    = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GLITCH_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_LOW     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_HIGH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_LOW      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_HIGH     = 3'd4;

    // Configuration reset values
    localparam logic [GLITCH_LIMIT_W-1:0]    GLITCH_LIMIT_RST = 17'd2000;
    localparam logic signed [TEMP_CFG_W-1:0] TEMP_LOW_RST     = 18'sd10000;
    localparam logic signed [TEMP_CFG_W-1:0] TEMP_HIGH_RST    = 18'sd30000;
    localparam logic [HUM_CFG_W-1:0]         HUM_LOW_RST      = 17'd0;
    localparam logic [HUM_CFG_W-1:0]         HUM_HIGH_RST     = 17'd100000;

    // Held values and means before the first accepted round
    localparam int HELD_RESET = -127000;

    // Per-round verdict flags passed from the merge stage to the output side
    typedef struct packed {
        logic cooler_ready;
        logic room_ready;
        logic cooler_rejected;
        logic lower_rejected;
        logic upper_rejected;
        logic any_error;
    } flags_t;

endpackage

### rtl/core/sgrf_lane.sv
// One change-check lane: tests two readings against their held values.
// Uses sgrf_pkg for the glitch limit width.
module sgrf_lane #(
    parameter int VW = 18
) (
    input  logic [sgrf_pkg::GLITCH_LIMIT_W-1:0] limit,
    input  logic signed [VW-1:0]                held_a,
    input  logic signed [VW-1:0]                held_b,
    input  logic signed [VW-1:0]                now_a,
    input  logic signed [VW-1:0]                now_b,
    output logic                                pass
);

    localparam int DW = VW + 1;
    localparam int CW = (DW > sgrf_pkg::GLITCH_LIMIT_W) ? DW : sgrf_pkg::GLITCH_LIMIT_W;

    logic signed [DW-1:0] diff_a;
    logic signed [DW-1:0] diff_b;
    logic [DW-1:0]        mag_a;
    logic [DW-1:0]        mag_b;
    logic [CW-1:0]        lim_w;

    always_comb
    begin
        diff_a = DW'(now_a) - DW'(held_a);
        diff_b = DW'(now_b) - DW'(held_b);
        // difference never reaches the most negative code, so negation is safe
        mag_a  = diff_a[DW-1] ? DW'(-diff_a) : DW'(diff_a);
        mag_b  = diff_b[DW-1] ? DW'(-diff_b) : DW'(diff_b);
        lim_w  = CW'(limit);
        pass   = (CW'(mag_a) <= lim_w) && (CW'(mag_b) <= lim_w);
    end

endmodule

### rtl/core/sgrf_merge.sv
// Merge stage: combines lane verdicts with priming checks, holds filter state.
// Uses sgrf_pkg (flags_t, config widths, reset constant).
module sgrf_merge #(
    parameter int SAMPLE_BITS = 18
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  take,
    input  logic signed [SAMPLE_BITS-1:0]         upper_temp,
    input  logic [SAMPLE_BITS-2:0]                upper_hum,
    input  logic signed [SAMPLE_BITS-1:0]         lower_temp,
    input  logic [SAMPLE_BITS-2:0]                lower_hum,
    input  logic signed [SAMPLE_BITS-1:0]         cooler_in_temp,
    input  logic signed [SAMPLE_BITS-1:0]         cooler_out_temp,
    input  logic                                  cooler_available,
    input  logic                                  cooler_fresh,
    input  logic signed [sgrf_pkg::TEMP_CFG_W-1:0] temp_low,
    input  logic signed [sgrf_pkg::TEMP_CFG_W-1:0] temp_high,
    input  logic [sgrf_pkg::HUM_CFG_W-1:0]        hum_low,
    input  logic [sgrf_pkg::HUM_CFG_W-1:0]        hum_high,
    input  logic                                  upper_pass,
    input  logic                                  lower_pass,
    input  logic                                  cooler_pass,
    output logic signed [SAMPLE_BITS-1:0]         cur_upper_temp,
    output logic [SAMPLE_BITS-2:0]                cur_upper_hum,
    output logic signed [SAMPLE_BITS-1:0]         cur_lower_temp,
    output logic [SAMPLE_BITS-2:0]                cur_lower_hum,
    output logic signed [SAMPLE_BITS-1:0]         cur_cooler_in,
    output logic signed [SAMPLE_BITS-1:0]         cur_cooler_out,
    output sgrf_pkg::flags_t                      flags,
    output logic signed [SAMPLE_BITS-1:0]         res_mean_temp,
    output logic signed [SAMPLE_BITS-1:0]         res_mean_hum,
    output logic signed [SAMPLE_BITS-1:0]         res_upper_temp,
    output logic signed [SAMPLE_BITS-1:0]         res_lower_temp,
    output logic signed [SAMPLE_BITS-1:0]         res_cooler_in,
    output logic signed [SAMPLE_BITS-1:0]         res_cooler_out
);

    localparam int SW1 = SAMPLE_BITS + 1;
    localparam int TW  = (SAMPLE_BITS > sgrf_pkg::TEMP_CFG_W) ? SAMPLE_BITS
                                                              : sgrf_pkg::TEMP_CFG_W;
    localparam int HW  = (SAMPLE_BITS - 1 > sgrf_pkg::HUM_CFG_W) ? SAMPLE_BITS - 1
                                                                 : sgrf_pkg::HUM_CFG_W;
    localparam logic signed [SAMPLE_BITS-1:0] HELD_INIT = SAMPLE_BITS'(sgrf_pkg::HELD_RESET);

    logic                          room_primed_reg,   room_primed_next;
    logic                          cooler_primed_reg, cooler_primed_next;
    logic signed [SAMPLE_BITS-1:0] upper_temp_reg,    upper_temp_next;
    logic [SAMPLE_BITS-2:0]        upper_hum_reg,     upper_hum_next;
    logic signed [SAMPLE_BITS-1:0] lower_temp_reg,    lower_temp_next;
    logic [SAMPLE_BITS-2:0]        lower_hum_reg,     lower_hum_next;
    logic signed [SAMPLE_BITS-1:0] cooler_in_reg,     cooler_in_next;
    logic signed [SAMPLE_BITS-1:0] cooler_out_reg,    cooler_out_next;
    logic signed [SAMPLE_BITS-1:0] avg_temp_reg,      avg_temp_next;
    logic signed [SAMPLE_BITS-1:0] avg_hum_reg,       avg_hum_next;

    logic signed [TW-1:0]  ut_w, lt_w, tlo_w, thi_w;
    logic [HW-1:0]         uh_w, lh_w, hlo_w, hhi_w;
    logic                  room_ok, cooler_ok;
    logic                  up_rej, lo_rej, co_rej;
    logic signed [SW1-1:0] temp_sum;
    logic [SAMPLE_BITS-1:0] hum_sum;

    always_comb
    begin
        ut_w  = TW'(upper_temp);
        lt_w  = TW'(lower_temp);
        tlo_w = TW'(temp_low);
        thi_w = TW'(temp_high);
        uh_w  = HW'(upper_hum);
        lh_w  = HW'(lower_hum);
        hlo_w = HW'(hum_low);
        hhi_w = HW'(hum_high);

        room_ok = (ut_w > tlo_w) && (ut_w < thi_w) && (lt_w > tlo_w) && (lt_w < thi_w) &&
                  (uh_w > hlo_w) && (uh_w < hhi_w) && (lh_w > hlo_w) && (lh_w < hhi_w);

        cooler_ok = cooler_available && cooler_fresh &&
                    !cooler_in_temp[SAMPLE_BITS-1] && (|cooler_in_temp) &&
                    !cooler_out_temp[SAMPLE_BITS-1] && (|cooler_out_temp);

        if (!room_primed_reg)
        begin
            up_rej = !room_ok;
            lo_rej = !room_ok;
        end
        else
        begin
            up_rej = !upper_pass;
            lo_rej = !lower_pass;
        end

        if (!cooler_primed_reg)
            co_rej = !cooler_ok;
        else
            co_rej = !(cooler_available && cooler_pass);

        // both room pairs pass: the new held values are this round's readings
        temp_sum = SW1'(upper_temp) + SW1'(lower_temp);
        hum_sum  = SAMPLE_BITS'(upper_hum) + SAMPLE_BITS'(lower_hum);

        room_primed_next   = room_primed_reg | room_ok;
        cooler_primed_next = cooler_primed_reg | cooler_ok;
        upper_temp_next    = up_rej ? upper_temp_reg : upper_temp;
        upper_hum_next     = up_rej ? upper_hum_reg  : upper_hum;
        lower_temp_next    = lo_rej ? lower_temp_reg : lower_temp;
        lower_hum_next     = lo_rej ? lower_hum_reg  : lower_hum;
        cooler_in_next     = co_rej ? cooler_in_reg  : cooler_in_temp;
        cooler_out_next    = co_rej ? cooler_out_reg : cooler_out_temp;
        avg_temp_next      = (up_rej || lo_rej) ? avg_temp_reg : temp_sum[SAMPLE_BITS:1];
        avg_hum_next       = (up_rej || lo_rej) ? avg_hum_reg
                                                : {1'b0, hum_sum[SAMPLE_BITS-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_primed_reg   <= 1'b0;
            cooler_primed_reg <= 1'b0;
            upper_temp_reg    <= HELD_INIT;
            lower_temp_reg    <= HELD_INIT;
            cooler_in_reg     <= HELD_INIT;
            cooler_out_reg    <= HELD_INIT;
            avg_temp_reg      <= HELD_INIT;
            avg_hum_reg       <= HELD_INIT;
        end
        else if (take)
        begin
            room_primed_reg   <= room_primed_next;
            cooler_primed_reg <= cooler_primed_next;
            upper_temp_reg    <= upper_temp_next;
            lower_temp_reg    <= lower_temp_next;
            cooler_in_reg     <= cooler_in_next;
            cooler_out_reg    <= cooler_out_next;
            avg_temp_reg      <= avg_temp_next;
            avg_hum_reg       <= avg_hum_next;
        end
    end

    // held humidities are only read after priming has loaded them
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            upper_hum_reg <= upper_hum_next;
            lower_hum_reg <= lower_hum_next;
        end
    end

    assign cur_upper_temp = upper_temp_reg;
    assign cur_upper_hum  = upper_hum_reg;
    assign cur_lower_temp = lower_temp_reg;
    assign cur_lower_hum  = lower_hum_reg;
    assign cur_cooler_in  = cooler_in_reg;
    assign cur_cooler_out = cooler_out_reg;

    assign flags.any_error       = up_rej | lo_rej | co_rej;
    assign flags.upper_rejected  = up_rej;
    assign flags.lower_rejected  = lo_rej;
    assign flags.cooler_rejected = co_rej;
    assign flags.room_ready      = room_primed_next;
    assign flags.cooler_ready    = cooler_primed_next;

    assign res_mean_temp  = avg_temp_next;
    assign res_mean_hum   = avg_hum_next;
    assign res_upper_temp = upper_temp_next;
    assign res_lower_temp = lower_temp_next;
    assign res_cooler_in  = cooler_in_next;
    assign res_cooler_out = cooler_out_next;

endmodule

### rtl/core/sgrf_skid.sv
// Two-entry output buffer: output register plus skid register.
// Standalone; no package dependency.
module sgrf_skid #(
    parameter int W = 120
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         out_valid_reg,  out_valid_next;
    logic [W-1:0] out_data_reg,   out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [W-1:0] skid_data_reg,  skid_data_next;
    logic         push, pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && !skid_valid_reg;
    assign pop      = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
                out_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/core/sensor_glitch_rejection_filter.sv
// Top level of the sensor glitch rejection filter: config registers, three
// check lanes, merge stage and output buffer. Uses sgrf_pkg, sgrf_lane,
// sgrf_merge and sgrf_skid.
//
//  Channel   Dir  Handshake           Payload
//  s_*       in   s_tvalid/s_tready   s_tdata: readings, s_tuser: cooler flags
//  m_*       out  m_tvalid/m_tready   m_tdata: verdict flags, means, held values
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One sampling round per cycle while s_tready is high; each result is formed
// combinationally by the merge logic and registered in the output buffer.
// s_tready drops only when both output entries are full (m_tready low for two
// results); cfg_ready is always high.
// Reset clears priming state, loads register defaults and empties the buffer.
module sensor_glitch_rejection_filter #(
    parameter int SAMPLE_BITS = 18
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // upper_temp, upper_hum, lower_temp, lower_hum, cooler_in_temp,
    // cooler_out_temp, zero pad
    input  logic [((6*SAMPLE_BITS-2+7)/8)*8-1:0]   s_tdata,
    // cooler_available, cooler_fresh
    input  logic [1:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // any_error, upper_rejected, lower_rejected, cooler_rejected, room_ready,
    // cooler_ready, mean_temp, mean_hum, held_upper_temp, held_lower_temp,
    // held_cooler_in, held_cooler_out, zero pad
    output logic [((6*SAMPLE_BITS+6+7)/8)*8-1:0]   m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sgrf_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [sgrf_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int S     = SAMPLE_BITS;
    localparam int OUT_W = ((6*SAMPLE_BITS+6+7)/8)*8;

    logic [sgrf_pkg::GLITCH_LIMIT_W-1:0]   glitch_limit_reg;
    logic signed [sgrf_pkg::TEMP_CFG_W-1:0] temp_low_reg;
    logic signed [sgrf_pkg::TEMP_CFG_W-1:0] temp_high_reg;
    logic [sgrf_pkg::HUM_CFG_W-1:0]        hum_low_reg;
    logic [sgrf_pkg::HUM_CFG_W-1:0]        hum_high_reg;

    logic signed [S-1:0] upper_temp, lower_temp, cooler_in_temp, cooler_out_temp;
    logic [S-2:0]        upper_hum, lower_hum;
    logic                take;

    logic signed [S-1:0] cur_upper_temp, cur_lower_temp, cur_cooler_in, cur_cooler_out;
    logic [S-2:0]        cur_upper_hum, cur_lower_hum;
    logic                upper_pass, lower_pass, cooler_pass;

    sgrf_pkg::flags_t    flags;
    logic signed [S-1:0] res_mean_temp, res_mean_hum;
    logic signed [S-1:0] res_upper_temp, res_lower_temp, res_cooler_in, res_cooler_out;
    logic [OUT_W-1:0]    res_vec;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glitch_limit_reg <= sgrf_pkg::GLITCH_LIMIT_RST;
            temp_low_reg     <= sgrf_pkg::TEMP_LOW_RST;
            temp_high_reg    <= sgrf_pkg::TEMP_HIGH_RST;
            hum_low_reg      <= sgrf_pkg::HUM_LOW_RST;
            hum_high_reg     <= sgrf_pkg::HUM_HIGH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sgrf_pkg::REG_GLITCH_LIMIT:
                    glitch_limit_reg <= cfg_data[sgrf_pkg::GLITCH_LIMIT_W-1:0];
                sgrf_pkg::REG_TEMP_LOW:
                    temp_low_reg <= cfg_data[sgrf_pkg::TEMP_CFG_W-1:0];
                sgrf_pkg::REG_TEMP_HIGH:
                    temp_high_reg <= cfg_data[sgrf_pkg::TEMP_CFG_W-1:0];
                sgrf_pkg::REG_HUM_LOW:
                    hum_low_reg <= cfg_data[sgrf_pkg::HUM_CFG_W-1:0];
                sgrf_pkg::REG_HUM_HIGH:
                    hum_high_reg <= cfg_data[sgrf_pkg::HUM_CFG_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // request unpacking
    assign upper_temp      = s_tdata[0 +: S];
    assign upper_hum       = s_tdata[S +: S-1];
    assign lower_temp      = s_tdata[2*S-1 +: S];
    assign lower_hum       = s_tdata[3*S-1 +: S-1];
    assign cooler_in_temp  = s_tdata[4*S-2 +: S];
    assign cooler_out_temp = s_tdata[5*S-2 +: S];

    assign take = s_tvalid && s_tready;

    // change-check lanes, one per reading pair
    sgrf_lane #(.VW(S)) u_lane_upper (
        .limit  (glitch_limit_reg),
        .held_a (cur_upper_temp),
        .held_b ($signed(S'(cur_upper_hum))),
        .now_a  (upper_temp),
        .now_b  ($signed(S'(upper_hum))),
        .pass   (upper_pass)
    );

    sgrf_lane #(.VW(S)) u_lane_lower (
        .limit  (glitch_limit_reg),
        .held_a (cur_lower_temp),
        .held_b ($signed(S'(cur_lower_hum))),
        .now_a  (lower_temp),
        .now_b  ($signed(S'(lower_hum))),
        .pass   (lower_pass)
    );

    sgrf_lane #(.VW(S)) u_lane_cooler (
        .limit  (glitch_limit_reg),
        .held_a (cur_cooler_in),
        .held_b (cur_cooler_out),
        .now_a  (cooler_in_temp),
        .now_b  (cooler_out_temp),
        .pass   (cooler_pass)
    );

    sgrf_merge #(.SAMPLE_BITS(S)) u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .upper_temp       (upper_temp),
        .upper_hum        (upper_hum),
        .lower_temp       (lower_temp),
        .lower_hum        (lower_hum),
        .cooler_in_temp   (cooler_in_temp),
        .cooler_out_temp  (cooler_out_temp),
        .cooler_available (s_tuser[0]),
        .cooler_fresh     (s_tuser[1]),
        .temp_low         (temp_low_reg),
        .temp_high        (temp_high_reg),
        .hum_low          (hum_low_reg),
        .hum_high         (hum_high_reg),
        .upper_pass       (upper_pass),
        .lower_pass       (lower_pass),
        .cooler_pass      (cooler_pass),
        .cur_upper_temp   (cur_upper_temp),
        .cur_upper_hum    (cur_upper_hum),
        .cur_lower_temp   (cur_lower_temp),
        .cur_lower_hum    (cur_lower_hum),
        .cur_cooler_in    (cur_cooler_in),
        .cur_cooler_out   (cur_cooler_out),
        .flags            (flags),
        .res_mean_temp    (res_mean_temp),
        .res_mean_hum     (res_mean_hum),
        .res_upper_temp   (res_upper_temp),
        .res_lower_temp   (res_lower_temp),
        .res_cooler_in    (res_cooler_in),
        .res_cooler_out   (res_cooler_out)
    );

    // result packing, first field in the low bits, zero pad on top
    assign res_vec = OUT_W'({res_cooler_out, res_cooler_in, res_lower_temp,
                             res_upper_temp, res_mean_hum, res_mean_temp,
                             flags.cooler_ready, flags.room_ready,
                             flags.cooler_rejected, flags.lower_rejected,
                             flags.upper_rejected, flags.any_error});

    sgrf_skid #(.W(OUT_W)) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res_vec),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

### bench/testbench.sv
// Self-checking bench for sensor_glitch_rejection_filter: sends sampling rounds and register
// writes, predicts every verdict in the bench and compares the results field by field.
// Depends on sgrf_pkg and the filter RTL.
module testbench;

    localparam int SB = 18;
    localparam int T_MIN = -131072;
    localparam int T_MAX = 131071;
    localparam int H_MAX = 131071;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WALK_PHASES = 7;
    localparam int WALK_ROUNDS = 42;
    // Index past the last register; a write there must change nothing
    localparam logic [sgrf_pkg::CFG_INDEX_W-1:0] REG_SPARE = 3'd6;

    // s_tdata in the low 112 bits, s_tuser on top
    typedef struct packed {
        logic               fresh;
        logic               avail;
        logic [5:0]         pad;
        logic signed [17:0] cooler_out;
        logic signed [17:0] cooler_in;
        logic [16:0]        lower_hum;
        logic signed [17:0] lower_temp;
        logic [16:0]        upper_hum;
        logic signed [17:0] upper_temp;
    } round_t;

    typedef struct packed {
        logic [5:0]         pad;
        logic signed [17:0] held_cooler_out;
        logic signed [17:0] held_cooler_in;
        logic signed [17:0] held_lower_temp;
        logic signed [17:0] held_upper_temp;
        logic signed [17:0] mean_hum;
        logic signed [17:0] mean_temp;
        sgrf_pkg::flags_t   flags;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [111:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [sgrf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [sgrf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Filter state and registers as the bench believes them to be
    logic [16:0] glitch_lim = sgrf_pkg::GLITCH_LIMIT_RST;
    int temp_lo = int'(sgrf_pkg::TEMP_LOW_RST);
    int temp_hi = int'(sgrf_pkg::TEMP_HIGH_RST);
    int hum_lo = int'(sgrf_pkg::HUM_LOW_RST);
    int hum_hi = int'(sgrf_pkg::HUM_HIGH_RST);
    bit room_up = 1'b0;
    bit cooler_up = 1'b0;
    int held_ut = sgrf_pkg::HELD_RESET;
    int held_uh = sgrf_pkg::HELD_RESET;
    int held_lt = sgrf_pkg::HELD_RESET;
    int held_lh = sgrf_pkg::HELD_RESET;
    int held_ci = sgrf_pkg::HELD_RESET;
    int held_co = sgrf_pkg::HELD_RESET;
    int avg_t = sgrf_pkg::HELD_RESET;
    int avg_h = sgrf_pkg::HELD_RESET;

    verdict_t awaited_verdicts[$];
    int faults = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stuck = 0;

    sensor_glitch_rejection_filter #(
        .SAMPLE_BITS(SB)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void set_register(logic [sgrf_pkg::CFG_INDEX_W-1:0] index,
                                         logic [sgrf_pkg::CFG_DATA_W-1:0] data);
        case (index)
            sgrf_pkg::REG_GLITCH_LIMIT: glitch_lim = data[16:0];
            sgrf_pkg::REG_TEMP_LOW:     temp_lo = int'($signed(data));
            sgrf_pkg::REG_TEMP_HIGH:    temp_hi = int'($signed(data));
            sgrf_pkg::REG_HUM_LOW:      hum_lo = int'(data[16:0]);
            sgrf_pkg::REG_HUM_HIGH:     hum_hi = int'(data[16:0]);
            default:                    ;
        endcase
    endfunction

    function automatic bit near(int held, int now);
        int d;
        d = now - held;
        if (d < 0)
            d = -d;
        return d <= int'(glitch_lim);
    endfunction

    // Advances the bench's copy of the filter by one round
    function automatic verdict_t judge_round(round_t r);
        int ut, uh, lt, lh, ci, co;
        bit ok, up_bad, lo_bad, co_bad;
        verdict_t v;
        ut = int'(r.upper_temp);
        uh = int'(r.upper_hum);
        lt = int'(r.lower_temp);
        lh = int'(r.lower_hum);
        ci = int'(r.cooler_in);
        co = int'(r.cooler_out);
        if (!room_up)
        begin
            ok = ut > temp_lo && ut < temp_hi && lt > temp_lo && lt < temp_hi &&
                 uh > hum_lo && uh < hum_hi && lh > hum_lo && lh < hum_hi;
            if (ok)
            begin
                held_ut = ut;
                held_uh = uh;
                held_lt = lt;
                held_lh = lh;
                avg_t = (ut + lt) >>> 1;
                avg_h = (uh + lh) >>> 1;
                room_up = 1'b1;
            end
            up_bad = !ok;
            lo_bad = !ok;
        end
        else
        begin
            up_bad = !(near(held_ut, ut) && near(held_uh, uh));
            lo_bad = !(near(held_lt, lt) && near(held_lh, lh));
            if (!up_bad)
            begin
                held_ut = ut;
                held_uh = uh;
            end
            if (!lo_bad)
            begin
                held_lt = lt;
                held_lh = lh;
            end
            if (!up_bad && !lo_bad)
            begin
                avg_t = (held_ut + held_lt) >>> 1;
                avg_h = (held_uh + held_lh) >>> 1;
            end
        end
        if (!cooler_up)
        begin
            ok = r.avail && r.fresh && ci > 0 && co > 0;
            if (ok)
            begin
                held_ci = ci;
                held_co = co;
                cooler_up = 1'b1;
            end
            co_bad = !ok;
        end
        else if (!r.avail)
        begin
            co_bad = 1'b1;
        end
        else
        begin
            co_bad = !(near(held_ci, ci) && near(held_co, co));
            if (!co_bad)
            begin
                held_ci = ci;
                held_co = co;
            end
        end
        v = '0;
        v.flags.any_error = up_bad || lo_bad || co_bad;
        v.flags.upper_rejected = up_bad;
        v.flags.lower_rejected = lo_bad;
        v.flags.cooler_rejected = co_bad;
        v.flags.room_ready = room_up;
        v.flags.cooler_ready = cooler_up;
        v.mean_temp = avg_t[17:0];
        v.mean_hum = avg_h[17:0];
        v.held_upper_temp = held_ut[17:0];
        v.held_lower_temp = held_lt[17:0];
        v.held_cooler_in = held_ci[17:0];
        v.held_cooler_out = held_co[17:0];
        return v;
    endfunction

    function automatic round_t make_round(int ut, int uh, int lt, int lh, int ci, int co,
                                          bit avail, bit fresh);
        round_t r;
        r = '0;
        r.upper_temp = ut[17:0];
        r.upper_hum = uh[16:0];
        r.lower_temp = lt[17:0];
        r.lower_hum = lh[16:0];
        r.cooler_in = ci[17:0];
        r.cooler_out = co[17:0];
        r.avail = avail;
        r.fresh = fresh;
        return r;
    endfunction

    function automatic int wander(int held, int span, int lo, int hi);
        int v;
        v = held + int'($urandom_range(2 * span)) - span;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    // Mostly small steps around the held values, some past the limit, some pure noise
    function automatic round_t walk_round();
        logic [127:0] raw;
        round_t r;
        int span;
        if ($urandom_range(99) < 8)
        begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            r = raw[113:0];
            r.pad = '0;
            return r;
        end
        span = int'(glitch_lim) + int'(glitch_lim) / 4 + 3;
        r = make_round(wander(held_ut, span, T_MIN, T_MAX), wander(held_uh, span, 0, H_MAX),
                       wander(held_lt, span, T_MIN, T_MAX), wander(held_lh, span, 0, H_MAX),
                       wander(held_ci, span, T_MIN, T_MAX), wander(held_co, span, T_MIN, T_MAX),
                       $urandom_range(99) < 85, 1'($urandom_range(1)));
        return r;
    endfunction

    // Leaves s_tvalid high so back-to-back requests need no second assignment
    task automatic send_round(round_t r);
        while (idle_on && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= r[111:0];
        s_tuser <= {r.fresh, r.avail};
        do @(posedge clk); while (!s_tready);
        awaited_verdicts.push_back(judge_round(r));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [sgrf_pkg::CFG_INDEX_W-1:0] index,
                             logic [sgrf_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        set_register(index, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !(idle_on && $urandom_range(99) < 25);
        end
    end

    always @(posedge clk)
    begin : check_results
        verdict_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (awaited_verdicts.size() == 0)
            begin
                $error("result with no request outstanding: %h", m_tdata);
                faults++;
            end
            else
            begin
                want = awaited_verdicts.pop_front();
                check_field("any_error", 32'(want.flags.any_error),
                            32'(got.flags.any_error));
                check_field("upper_rejected", 32'(want.flags.upper_rejected),
                            32'(got.flags.upper_rejected));
                check_field("lower_rejected", 32'(want.flags.lower_rejected),
                            32'(got.flags.lower_rejected));
                check_field("cooler_rejected", 32'(want.flags.cooler_rejected),
                            32'(got.flags.cooler_rejected));
                check_field("room_ready", 32'(want.flags.room_ready),
                            32'(got.flags.room_ready));
                check_field("cooler_ready", 32'(want.flags.cooler_ready),
                            32'(got.flags.cooler_ready));
                check_field("mean_temp", 32'(want.mean_temp), 32'(got.mean_temp));
                check_field("mean_hum", 32'(want.mean_hum), 32'(got.mean_hum));
                check_field("held_upper_temp", 32'(want.held_upper_temp),
                            32'(got.held_upper_temp));
                check_field("held_lower_temp", 32'(want.held_lower_temp),
                            32'(got.held_lower_temp));
                check_field("held_cooler_in", 32'(want.held_cooler_in),
                            32'(got.held_cooler_in));
                check_field("held_cooler_out", 32'(want.held_cooler_out),
                            32'(got.held_cooler_out));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            stuck = 0;
        end
        else
        begin
            stuck++;
            if (stuck >= WATCHDOG_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Window bounds are exclusive; the room group stays unprimed until the last round here
    task automatic test_priming_windows();
        send_round(make_round(10000, 50000, 20000, 50000, 5000, 5000, 1'b1, 1'b0));
        send_round(make_round(20000, 50000, 30000, 50000, 5000, 5000, 1'b0, 1'b1));
        send_round(make_round(20000, 0, 20000, 50000, 0, 5000, 1'b1, 1'b1));
        send_round(make_round(20000, 50000, 20000, 100000, 5000, -55000, 1'b1, 1'b1));
        // cooler primes by itself while the room group keeps waiting
        send_round(make_round(-40000, 50000, 20000, 50000, 1, 125000, 1'b1, 1'b1));
        send_round(make_round(9999, 50000, 20000, 50000, 9000, 9000, 1'b0, 1'b0));
        drain();
        // empty humidity window
        write_reg(sgrf_pkg::REG_TEMP_LOW, 18'(-40000));
        write_reg(sgrf_pkg::REG_TEMP_HIGH, 18'(125000));
        write_reg(sgrf_pkg::REG_HUM_LOW, 18'(100000));
        write_reg(sgrf_pkg::REG_HUM_HIGH, 18'(0));
        send_round(make_round(0, 50000, 0, 50000, 1, 125000, 1'b1, 1'b1));
        drain();
        // inverted temperature window
        write_reg(sgrf_pkg::REG_TEMP_LOW, 18'(125000));
        write_reg(sgrf_pkg::REG_TEMP_HIGH, 18'(-40000));
        write_reg(sgrf_pkg::REG_HUM_LOW, 18'(0));
        write_reg(sgrf_pkg::REG_HUM_HIGH, 18'(100000));
        write_reg(REG_SPARE, 18'h3FFFF);
        send_round(make_round(0, 50000, 0, 50000, 2, 125000, 1'b1, 1'b0));
        drain();
        // widest windows; humidity high written with a bit above the register width
        write_reg(sgrf_pkg::REG_TEMP_LOW, 18'h20000);
        write_reg(sgrf_pkg::REG_TEMP_HIGH, 18'h1FFFF);
        write_reg(sgrf_pkg::REG_HUM_HIGH, 18'h3FFFF);
        send_round(make_round(T_MIN, 1, 0, 1, 3, 125000, 1'b1, 1'b1));
        // primes with a negative odd sum, so the mean rounds down
        send_round(make_round(T_MIN + 1, 1, T_MAX - 1, H_MAX - 1, 4, 125000, 1'b0, 1'b1));
        drain();
    endtask

    task automatic test_change_limits();
        write_reg(sgrf_pkg::REG_GLITCH_LIMIT, 18'(2000));
        // a change of exactly the limit passes in both directions
        send_round(make_round(held_ut + 2000, held_uh + 2000, held_lt - 2000, held_lh - 2000,
                              held_ci + 2000, held_co - 2000, 1'b1, 1'b0));
        // one past the limit rejects the pair that moved; a room reject holds the means
        send_round(make_round(held_ut + 2001, held_uh, held_lt, held_lh, held_ci, held_co,
                              1'b0, 1'b1));
        send_round(make_round(held_ut, held_uh, held_lt, held_lh - 2001, held_ci,
                              held_co + 2001, 1'b1, 1'b1));
        send_round(make_round(held_ut - 7, held_uh + 3, held_lt + 5, held_lh - 1,
                              held_ci - 2001, held_co, 1'b1, 1'b0));
        drain();
        write_reg(sgrf_pkg::REG_GLITCH_LIMIT, 18'(0));
        send_round(make_round(held_ut, held_uh, held_lt, held_lh, held_ci, held_co, 1'b1, 1'b1));
        send_round(make_round(held_ut + 1, held_uh, held_lt, held_lh, held_ci, held_co - 1,
                              1'b1, 1'b1));
        drain();
        // bit above the width masked off, so the limit is the largest the register holds
        write_reg(sgrf_pkg::REG_GLITCH_LIMIT, 18'h3FFFF);
        send_round(make_round(held_ut + 131071, H_MAX, held_lt - 131072, 0, T_MAX, T_MIN,
                              1'b1, 1'b1));
        send_round(make_round(held_ut, held_uh, held_lt - 131071, held_lh, held_ci, held_co,
                              1'b1, 1'b0));
        drain();
    endtask

    task automatic test_random_walk();
        logic [16:0] limits [WALK_PHASES] = '{17'd2000, 17'd0, 17'd100000, 17'd1, 17'd20000,
                                              17'd500, 17'd7000};
        for (int p = 0; p < WALK_PHASES; p++)
        begin
            drain();
            write_reg(sgrf_pkg::REG_GLITCH_LIMIT, {1'b0, limits[p]});
            // windows only matter before priming, but the writes must still be harmless
            write_reg(sgrf_pkg::REG_TEMP_LOW, 18'($urandom));
            write_reg(sgrf_pkg::REG_TEMP_HIGH, 18'($urandom));
            write_reg(sgrf_pkg::REG_HUM_LOW, 18'($urandom));
            write_reg(sgrf_pkg::REG_HUM_HIGH, 18'($urandom));
            repeat (WALK_ROUNDS) send_round(walk_round());
        end
        drain();
        write_reg(sgrf_pkg::REG_GLITCH_LIMIT, 18'($urandom_range(0, 100000)));
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (60) send_round(walk_round());
        idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, so the output buffer fills
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (30) send_round(walk_round());
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_priming_windows();
        test_change_limits();
        test_random_walk();
        test_no_idle();
        test_backpressure();
        drain();
        if (awaited_verdicts.size() != 0)
        begin
            $error("%0d results never arrived", awaited_verdicts.size());
            faults++;
        end
        if (faults == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### sim.f
rtl/core/sgrf_pkg.sv
rtl/core/sgrf_lane.sv
rtl/core/sgrf_merge.sv
rtl/core/sgrf_skid.sv
rtl/core/sensor_glitch_rejection_filter.sv
bench/testbench.sv
